// ===== hdl/imu_gesture_classifier_macros.svh =====
// Assertion macros for the gesture classifier checker
`ifndef IMU_GESTURE_CLASSIFIER_MACROS_SVH
`define IMU_GESTURE_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define IGC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("igc assertion failed");

// next-cycle implication, disabled while reset is low
`define IGC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("igc assertion failed");

`endif

// ===== hdl/igc_pkg.sv =====
// Types and constants of the IMU gesture classifier
`default_nettype none

package igc_pkg;

    localparam int MUL_W      = 64;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int TAIL       = 10;
    localparam int HALF_SHIFT = 22;                        // (2048 n)^2 = n^2 << 22
    localparam logic [MUL_W-1:0]   COS_SQ     = 64'd244985104;  // 15652^2
    localparam logic signed [16:0] STEP_LIMIT = 17'sd3276;      // 0.8 g

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_DETECT = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_GRAV_X   = 3'd0,
        CFG_GRAV_Y   = 3'd1,
        CFG_GRAV_Z   = 3'd2,
        CFG_TILT     = 3'd3,
        CFG_SHAKE    = 3'd4,
        CFG_PUNCH    = 3'd5,
        CFG_SWIPE    = 3'd6,
        CFG_DEBOUNCE = 3'd7
    } cfg_t;

    typedef enum logic [3:0] {
        G_NONE    = 4'd0,
        G_TILT_L  = 4'd1,
        G_TILT_R  = 4'd2,
        G_TILT_F  = 4'd3,
        G_TILT_B  = 4'd4,
        G_SHAKE_X = 4'd5,
        G_SHAKE_Y = 4'd6,
        G_SHAKE_Z = 4'd7,
        G_PUNCH   = 4'd8,
        G_SWIPE_L = 4'd9,
        G_SWIPE_R = 4'd10
    } gest_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM_RD,
        S_SUM_ACC,
        S_MUL_GO,
        S_MUL_RUN,
        S_TAIL_RD,
        S_TAIL_DAT,
        S_TAIL_END,
        S_FIN,
        S_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_SX2, OP_SY2, OP_SZ2, OP_NN,
        OP_DX, OP_DY, OP_DZ, OP_DD, OP_KS,
        OP_CX1, OP_CX2, OP_CY1, OP_CY2,
        OP_CC, OP_LL, OP_LS, OP_SW
    } op_t;

    typedef struct packed {
        logic [31:0]        t;
        logic signed [15:0] gz;
        logic signed [15:0] gy;
        logic signed [15:0] gx;
        logic signed [15:0] az;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
    } sample_t;

endpackage

`default_nettype wire

// ===== hdl/igc_ram.sv =====
// Generic single-port-write RAM with registered read
`default_nettype none

module igc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
)(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/igc_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, stops when the rest is zero
`default_nettype none

module igc_mul
    import igc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [MUL_W-1:0]  a,
    input  wire logic [MUL_W-1:0]  b,
    output logic                   busy,
    output logic      [PROD_W-1:0] prod
);

    logic              run_reg, run_next;
    logic [PROD_W-1:0] a_reg, a_next;
    logic [PROD_W-1:0] p_reg, p_next;
    logic [MUL_W-1:0]  b_reg, b_next;

    always_comb
    begin
        run_next = run_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        p_next   = p_reg;
        if (start)
        begin
            run_next = 1'b1;
            a_next   = PROD_W'(a);
            b_next   = b;
            p_next   = '0;
        end
        else if (run_reg)
        begin
            if (b_reg == '0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                if (b_reg[0])
                begin
                    p_next = p_reg + a_reg;
                end
                a_next = a_reg << 1;
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign busy = run_reg;
    assign prod = p_reg;

endmodule

`default_nettype wire

// ===== hdl/imu_gesture_classifier.sv =====
// Push and clear are taken in the idle state; detect reads the newest min(fill,RECENT) samples
// and then runs up to 18 products, all on the single shift-add multiplier.
// One request at a time; after a detect, in_ready is low until the result is taken.
// Reset: async, clears ring bookkeeping, debounce state and config registers;
// the sample RAM is not cleared, only entries written since are ever read.
`default_nettype none

module imu_gesture_classifier
    import igc_pkg::*;
#(
    parameter int WINDOW = 64,
    parameter int RECENT = 8
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] accel_x,
    input  wire logic [15:0] accel_y,
    input  wire logic [15:0] accel_z,
    input  wire logic [15:0] gyro_x,
    input  wire logic [15:0] gyro_y,
    input  wire logic [15:0] gyro_z,
    input  wire logic [31:0] time_us,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       gesture,
    output logic [3:0]       previous_gesture,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [39:0] cfg_data
);

    localparam int AW    = $clog2(WINDOW);
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int SUM_W = 17 + $clog2(RECENT);
    localparam int NCAP  = (RECENT < WINDOW) ? RECENT : WINDOW;
    localparam logic [AW-1:0] WIN_LAST  = AW'(WINDOW - 1);
    localparam logic [AW-1:0] TAIL_A    = AW'(TAIL);
    localparam logic [AW-1:0] TAIL_WRAP = AW'(WINDOW - TAIL);
    localparam logic [CW-1:0] NCAP_C    = CW'(NCAP);
    localparam logic [CW-1:0] FULL_C    = CW'(WINDOW);
    localparam logic [CW-1:0] HALF_C    = CW'(WINDOW / 2);
    localparam logic [CW-1:0] TAIL_END  = CW'(TAIL - 1);

    function automatic logic [16:0] abs17(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = 17'(v);
        return w[16] ? 17'(-w) : 17'(w);
    endfunction

    function automatic logic [MUL_W-1:0] absw(input logic signed [MUL_W-1:0] v);
        return v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
    endfunction

    // control
    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] wslot_reg, wslot_next;
    logic [31:0]   last_time_reg, last_time_next;
    gest_t         last_code_reg, last_code_next;
    gest_t         prev_code_reg, prev_code_next;
    gest_t         res_reg, res_next;
    logic          tfirst_reg, tfirst_next;
    logic          swfirst_reg, swfirst_next;
    logic          hit_reg, hit_next;
    logic          punch_reg, punch_next;
    logic          neg_reg, neg_next;

    // configuration
    logic signed [15:0] grav_x_reg, grav_x_next;
    logic signed [15:0] grav_y_reg, grav_y_next;
    logic signed [15:0] grav_z_reg, grav_z_next;
    logic [14:0] tilt_reg, tilt_next;
    logic [14:0] shake_reg, shake_next;
    logic [14:0] punch_lim_reg, punch_lim_next;
    logic [39:0] swipe_reg, swipe_next;
    logic [31:0] deb_reg, deb_next;

    // datapath
    logic signed [SUM_W-1:0]  sx_reg, sx_next, sy_reg, sy_next, sz_reg, sz_next;
    logic [16:0]              gmx_reg, gmx_next, gmy_reg, gmy_next, gmz_reg, gmz_next;
    logic [16:0]              amz_reg, amz_next;
    logic [MUL_W-1:0]         s2_reg, s2_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0]        t1_reg, t1_next;
    logic signed [MUL_W-1:0]  dot_reg, dot_next, cx_reg, cx_next, cy_reg, cy_next;
    logic signed [MUL_W-1:0]  cum_reg, cum_next, vmax_reg, vmax_next, vmin_reg, vmin_next;
    logic signed [15:0]       pax_reg, pax_next, paz_reg, paz_next;
    logic [31:0]              pt_reg, pt_next;
    logic [31:0]              now_reg, now_next;

    // ram and multiplier
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [127:0]      ram_wdata, ram_rdata;
    sample_t           smp, wsmp;
    logic              mul_start, mul_busy;
    logic [PROD_W-1:0] mul_prod;
    logic signed [MUL_W-1:0]  opa, opb;
    logic signed [PROD_W-1:0] prod_s, sum_w, diff_w;
    logic signed [MUL_W-1:0]  swl, cum_sum;
    logic signed [16:0]       step_d;
    logic [AW-1:0]     ptr_dec, ptr_inc, tail_start;
    logic [CW-1:0]     n_pick;
    logic              cx_big;
    logic [31:0]       elapsed, dt;

    assign smp       = sample_t'(ram_rdata);
    assign ptr_dec   = (ptr_reg == '0) ? WIN_LAST : ptr_reg - AW'(1);
    assign ptr_inc   = (ptr_reg == WIN_LAST) ? '0 : ptr_reg + AW'(1);
    assign tail_start = (wslot_reg >= TAIL_A) ? wslot_reg - TAIL_A : wslot_reg + TAIL_WRAP;
    assign n_pick    = (fill_reg < NCAP_C) ? fill_reg : NCAP_C;
    assign cx_big    = absw(cx_reg) > absw(cy_reg);
    assign elapsed   = time_us - last_time_reg;
    assign dt        = smp.t - pt_reg;
    assign prod_s    = neg_reg ? -$signed(mul_prod) : $signed(mul_prod);
    assign sum_w     = acc_reg + prod_s;
    assign diff_w    = acc_reg - prod_s;
    assign cum_sum   = cum_reg + prod_s[MUL_W-1:0];
    assign swl       = $signed({24'd0, swipe_reg});
    assign step_d    = 17'(smp.az) - 17'(paz_reg);

    assign wsmp.t  = time_us;
    assign wsmp.gz = gyro_z;
    assign wsmp.gy = gyro_y;
    assign wsmp.gx = gyro_x;
    assign wsmp.az = accel_z;
    assign wsmp.ay = accel_y;
    assign wsmp.ax = accel_x;
    assign ram_wdata = wsmp;
    assign ram_waddr = wslot_reg;

    // multiplier operand select
    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (op_reg)
            OP_SX2:
            begin
                opa = MUL_W'(sx_reg);
                opb = MUL_W'(sx_reg);
            end
            OP_SY2:
            begin
                opa = MUL_W'(sy_reg);
                opb = MUL_W'(sy_reg);
            end
            OP_SZ2:
            begin
                opa = MUL_W'(sz_reg);
                opb = MUL_W'(sz_reg);
            end
            OP_NN:
            begin
                opa = MUL_W'(n_reg);
                opb = MUL_W'(n_reg);
            end
            OP_DX:
            begin
                opa = MUL_W'(sx_reg);
                opb = MUL_W'(grav_x_reg);
            end
            OP_DY:
            begin
                opa = MUL_W'(sy_reg);
                opb = MUL_W'(grav_y_reg);
            end
            OP_DZ:
            begin
                opa = MUL_W'(sz_reg);
                opb = MUL_W'(grav_z_reg);
            end
            OP_DD:
            begin
                opa = dot_reg;
                opb = dot_reg;
            end
            OP_KS:
            begin
                opa = $signed(COS_SQ);
                opb = $signed(s2_reg);
            end
            OP_CX1:
            begin
                opa = MUL_W'(grav_y_reg);
                opb = MUL_W'(sz_reg);
            end
            OP_CX2:
            begin
                opa = MUL_W'(grav_z_reg);
                opb = MUL_W'(sy_reg);
            end
            OP_CY1:
            begin
                opa = MUL_W'(grav_z_reg);
                opb = MUL_W'(sx_reg);
            end
            OP_CY2:
            begin
                opa = MUL_W'(grav_x_reg);
                opb = MUL_W'(sz_reg);
            end
            OP_CC:
            begin
                opa = cx_big ? cx_reg : cy_reg;
                opb = cx_big ? cx_reg : cy_reg;
            end
            OP_LL:
            begin
                opa = $signed(MUL_W'(tilt_reg));
                opb = $signed(MUL_W'(tilt_reg));
            end
            OP_LS:
            begin
                opa = acc_reg[MUL_W-1:0];
                opb = $signed(s2_reg);
            end
            OP_SW:
            begin
                opa = MUL_W'(pax_reg);
                opb = $signed(MUL_W'(dt));
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        fill_next      = fill_reg;
        wslot_next     = wslot_reg;
        last_time_next = last_time_reg;
        last_code_next = last_code_reg;
        prev_code_next = prev_code_reg;
        res_next       = res_reg;
        tfirst_next    = tfirst_reg;
        swfirst_next   = swfirst_reg;
        hit_next       = hit_reg;
        punch_next     = punch_reg;
        neg_next       = neg_reg;
        grav_x_next    = grav_x_reg;
        grav_y_next    = grav_y_reg;
        grav_z_next    = grav_z_reg;
        tilt_next      = tilt_reg;
        shake_next     = shake_reg;
        punch_lim_next = punch_lim_reg;
        swipe_next     = swipe_reg;
        deb_next       = deb_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        sz_next        = sz_reg;
        gmx_next       = gmx_reg;
        gmy_next       = gmy_reg;
        gmz_next       = gmz_reg;
        amz_next       = amz_reg;
        s2_next        = s2_reg;
        acc_next       = acc_reg;
        t1_next        = t1_reg;
        dot_next       = dot_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cum_next       = cum_reg;
        vmax_next      = vmax_reg;
        vmin_next      = vmin_reg;
        pax_next       = pax_reg;
        paz_next       = paz_reg;
        pt_next        = pt_reg;
        now_next       = now_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = ptr_reg;
        mul_start      = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_t'(cfg_index))
                CFG_GRAV_X:   grav_x_next    = cfg_data[15:0];
                CFG_GRAV_Y:   grav_y_next    = cfg_data[15:0];
                CFG_GRAV_Z:   grav_z_next    = cfg_data[15:0];
                CFG_TILT:     tilt_next      = cfg_data[14:0];
                CFG_SHAKE:    shake_next     = cfg_data[14:0];
                CFG_PUNCH:    punch_lim_next = cfg_data[14:0];
                CFG_SWIPE:    swipe_next     = cfg_data;
                CFG_DEBOUNCE: deb_next       = cfg_data[31:0];
                default:      deb_next       = deb_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_PUSH)
                    begin
                        ram_we     = 1'b1;
                        wslot_next = (wslot_reg == WIN_LAST) ? '0 : wslot_reg + AW'(1);
                        if (fill_reg < FULL_C)
                        begin
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                    else if (command == CMD_CLEAR)
                    begin
                        fill_next  = '0;
                        wslot_next = '0;
                    end
                    else if (command == CMD_DETECT)
                    begin
                        now_next       = time_us;
                        prev_code_next = last_code_reg;
                        n_next         = n_pick;
                        sx_next        = '0;
                        sy_next        = '0;
                        sz_next        = '0;
                        gmx_next       = '0;
                        gmy_next       = '0;
                        gmz_next       = '0;
                        amz_next       = '0;
                        ptr_next       = wslot_reg;
                        cnt_next       = '0;
                        if (fill_reg < HALF_C || elapsed < deb_reg || n_pick == '0)
                        begin
                            res_next   = G_NONE;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_SUM_RD;
                        end
                    end
                end
            end

            S_SUM_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ptr_dec;
                ptr_next   = ptr_dec;
                state_next = S_SUM_ACC;
            end

            S_SUM_ACC:
            begin
                sx_next = sx_reg + SUM_W'(smp.ax);
                sy_next = sy_reg + SUM_W'(smp.ay);
                sz_next = sz_reg + SUM_W'(smp.az);
                if (abs17(smp.gx) > gmx_reg) gmx_next = abs17(smp.gx);
                if (abs17(smp.gy) > gmy_reg) gmy_next = abs17(smp.gy);
                if (abs17(smp.gz) > gmz_reg) gmz_next = abs17(smp.gz);
                if (abs17(smp.az) > amz_reg) amz_next = abs17(smp.az);
                if (cnt_reg + CW'(1) == n_reg)
                begin
                    op_next    = OP_SX2;
                    state_next = S_MUL_GO;
                end
                else
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_SUM_RD;
                end
            end

            S_MUL_GO:
            begin
                mul_start  = 1'b1;
                neg_next   = opa[MUL_W-1] ^ opb[MUL_W-1];
                state_next = S_MUL_RUN;
            end

            S_MUL_RUN:
            begin
                if (!mul_busy)
                begin
                    state_next = S_MUL_GO;
                    unique case (op_reg)
                        OP_SX2:
                        begin
                            acc_next = prod_s;
                            op_next  = OP_SY2;
                        end
                        OP_SY2:
                        begin
                            acc_next = sum_w;
                            op_next  = OP_SZ2;
                        end
                        OP_SZ2:
                        begin
                            s2_next = sum_w[MUL_W-1:0];
                            op_next = OP_NN;
                        end
                        OP_NN:
                        begin
                            // weak mean, then shake, punch, then tilt or swipe in priority order
                            if (PROD_W'(s2_reg) <= (mul_prod << HALF_SHIFT))
                            begin
                                res_next   = G_NONE;
                                state_next = S_FIN;
                            end
                            else if (gmx_reg > 17'(shake_reg))
                            begin
                                res_next   = G_SHAKE_X;
                                state_next = S_FIN;
                            end
                            else if (gmy_reg > 17'(shake_reg))
                            begin
                                res_next   = G_SHAKE_Y;
                                state_next = S_FIN;
                            end
                            else if (gmz_reg > 17'(shake_reg))
                            begin
                                res_next   = G_SHAKE_Z;
                                state_next = S_FIN;
                            end
                            else if (amz_reg > 17'(punch_lim_reg))
                            begin
                                punch_next   = 1'b1;
                                ptr_next     = tail_start;
                                cnt_next     = '0;
                                tfirst_next  = 1'b1;
                                swfirst_next = 1'b1;
                                hit_next     = 1'b0;
                                state_next   = S_TAIL_RD;
                            end
                            else
                            begin
                                op_next = OP_DX;
                            end
                        end
                        OP_DX:
                        begin
                            acc_next = prod_s;
                            op_next  = OP_DY;
                        end
                        OP_DY:
                        begin
                            acc_next = sum_w;
                            op_next  = OP_DZ;
                        end
                        OP_DZ:
                        begin
                            dot_next = sum_w[MUL_W-1:0];
                            op_next  = sum_w[PROD_W-1] ? OP_CX1 : OP_DD;
                        end
                        OP_DD:
                        begin
                            t1_next = mul_prod;
                            op_next = OP_KS;
                        end
                        OP_KS:
                        begin
                            // dot^2 < cos^2 * |s|^2 means tilted
                            if (t1_reg < mul_prod)
                            begin
                                op_next = OP_CX1;
                            end
                            else
                            begin
                                punch_next   = 1'b0;
                                ptr_next     = tail_start;
                                cnt_next     = '0;
                                tfirst_next  = 1'b1;
                                swfirst_next = 1'b1;
                                hit_next     = 1'b0;
                                state_next   = S_TAIL_RD;
                            end
                        end
                        OP_CX1:
                        begin
                            acc_next = prod_s;
                            op_next  = OP_CX2;
                        end
                        OP_CX2:
                        begin
                            cx_next = diff_w[MUL_W-1:0];
                            op_next = OP_CY1;
                        end
                        OP_CY1:
                        begin
                            acc_next = prod_s;
                            op_next  = OP_CY2;
                        end
                        OP_CY2:
                        begin
                            cy_next = diff_w[MUL_W-1:0];
                            op_next = OP_CC;
                        end
                        OP_CC:
                        begin
                            t1_next = mul_prod;
                            op_next = OP_LL;
                        end
                        OP_LL:
                        begin
                            acc_next = prod_s;
                            op_next  = OP_LS;
                        end
                        OP_LS:
                        begin
                            state_next = S_FIN;
                            if (t1_reg > mul_prod)
                            begin
                                if (cx_big)
                                begin
                                    res_next = (cx_reg > 0) ? G_TILT_F : G_TILT_B;
                                end
                                else
                                begin
                                    res_next = (cy_reg > 0) ? G_TILT_R : G_TILT_L;
                                end
                            end
                            else
                            begin
                                res_next = G_NONE;
                            end
                        end
                        OP_SW:
                        begin
                            cum_next     = cum_sum;
                            swfirst_next = 1'b0;
                            if (swfirst_reg || cum_sum > vmax_reg) vmax_next = cum_sum;
                            if (swfirst_reg || cum_sum < vmin_reg) vmin_next = cum_sum;
                            pax_next = smp.ax;
                            paz_next = smp.az;
                            pt_next  = smp.t;
                            if (cnt_reg == TAIL_END)
                            begin
                                state_next = S_TAIL_END;
                            end
                            else
                            begin
                                cnt_next   = cnt_reg + CW'(1);
                                ptr_next   = ptr_inc;
                                state_next = S_TAIL_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_TAIL_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ptr_reg;
                state_next = S_TAIL_DAT;
            end

            S_TAIL_DAT:
            begin
                if (!tfirst_reg && !punch_reg)
                begin
                    // swipe: integrate previous accel_x over the step to this sample
                    op_next    = OP_SW;
                    state_next = S_MUL_GO;
                end
                else
                begin
                    if (!tfirst_reg && (step_d > STEP_LIMIT || step_d < -STEP_LIMIT))
                    begin
                        hit_next = 1'b1;
                    end
                    tfirst_next = 1'b0;
                    cum_next    = '0;
                    pax_next    = smp.ax;
                    paz_next    = smp.az;
                    pt_next     = smp.t;
                    if (cnt_reg == TAIL_END)
                    begin
                        state_next = S_TAIL_END;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CW'(1);
                        ptr_next   = ptr_inc;
                        state_next = S_TAIL_RD;
                    end
                end
            end

            S_TAIL_END:
            begin
                state_next = S_FIN;
                if (punch_reg)
                begin
                    res_next = hit_reg ? G_PUNCH : G_NONE;
                end
                else if (vmax_reg > swl)
                begin
                    res_next = G_SWIPE_R;
                end
                else if (vmin_reg < -swl)
                begin
                    res_next = G_SWIPE_L;
                end
                else
                begin
                    res_next = G_NONE;
                end
            end

            S_FIN:
            begin
                if (res_reg != G_NONE)
                begin
                    last_code_next = res_reg;
                    last_time_next = now_reg;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_SX2;
            fill_reg      <= '0;
            wslot_reg     <= '0;
            last_time_reg <= '0;
            last_code_reg <= G_NONE;
            tfirst_reg    <= 1'b0;
            swfirst_reg   <= 1'b0;
            punch_reg     <= 1'b0;
            grav_x_reg    <= 16'sd0;
            grav_y_reg    <= 16'sd0;
            grav_z_reg    <= 16'sd16384;
            tilt_reg      <= 15'd13107;
            shake_reg     <= 15'd2400;
            punch_lim_reg <= 15'd6144;
            swipe_reg     <= 40'd4915200000;
            deb_reg       <= 32'd300000;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            fill_reg      <= fill_next;
            wslot_reg     <= wslot_next;
            last_time_reg <= last_time_next;
            last_code_reg <= last_code_next;
            tfirst_reg    <= tfirst_next;
            swfirst_reg   <= swfirst_next;
            punch_reg     <= punch_next;
            grav_x_reg    <= grav_x_next;
            grav_y_reg    <= grav_y_next;
            grav_z_reg    <= grav_z_next;
            tilt_reg      <= tilt_next;
            shake_reg     <= shake_next;
            punch_lim_reg <= punch_lim_next;
            swipe_reg     <= swipe_next;
            deb_reg       <= deb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        cnt_reg       <= cnt_next;
        n_reg         <= n_next;
        prev_code_reg <= prev_code_next;
        res_reg       <= res_next;
        hit_reg       <= hit_next;
        neg_reg       <= neg_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        sz_reg        <= sz_next;
        gmx_reg       <= gmx_next;
        gmy_reg       <= gmy_next;
        gmz_reg       <= gmz_next;
        amz_reg       <= amz_next;
        s2_reg        <= s2_next;
        acc_reg       <= acc_next;
        t1_reg        <= t1_next;
        dot_reg       <= dot_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cum_reg       <= cum_next;
        vmax_reg      <= vmax_next;
        vmin_reg      <= vmin_next;
        pax_reg       <= pax_next;
        paz_reg       <= paz_next;
        pt_reg        <= pt_next;
        now_reg       <= now_next;
    end

    igc_ram #(
        .WIDTH (128),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    igc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (absw(opa)),
        .b     (absw(opb)),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = (state_reg == S_OUT);
    assign gesture          = res_reg;
    assign previous_gesture = prev_code_reg;
    assign cfg_ready        = 1'b1;

endmodule

`default_nettype wire

// ===== hdl/igc_checker.sv =====
// Port-level checks for the gesture classifier, bound to the top level
`default_nettype none
`include "imu_gesture_classifier_macros.svh"

module igc_checker
    import igc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  command,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [3:0]  gesture,
    input wire logic [3:0]  previous_gesture
);

    // stalled result holds
    `IGC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(gesture) && $stable(previous_gesture))

    // no new request is taken while a result is pending
    `IGC_ASSERT_IMPLIES(a_one_open, clk, rst_n, in_ready, !out_valid)

    `IGC_ASSERT_IMPLIES(a_code_range, clk, rst_n, out_valid, gesture <= G_SWIPE_R && previous_gesture <= G_SWIPE_R)

    // push, clear and unused codes never produce a result
    `IGC_ASSERT_NEXT(a_no_result, clk, rst_n, in_valid && in_ready && command != CMD_DETECT, !out_valid)

    `IGC_ASSERT_NEXT(a_single, clk, rst_n, out_valid && out_ready, !out_valid)

endmodule

bind imu_gesture_classifier igc_checker u_igc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .gesture          (gesture),
    .previous_gesture (previous_gesture)
);

`default_nettype wire

// ===== bench/imu_gesture_classifier_test.sv =====
// Self-checking bench for the IMU gesture classifier: random gesture sequences vs. a predictor
`timescale 1ns / 100ps

module imu_gesture_classifier_test;
    import igc_pkg::*;

    localparam int RING   = 64;
    localparam int NEWEST = 8;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] ax, ay, az, gx, gy, gz;
        logic [31:0] t;
    } imu_req_t;

    typedef struct {
        logic [3:0] g;
        logic [3:0] prev;
    } gest_pair_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [15:0] accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z;
    logic [31:0] time_us;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  gesture;
    logic [3:0]  previous_gesture;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [39:0] cfg_data;

    imu_gesture_classifier u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z), .time_us(time_us),
        .out_valid(out_valid), .out_ready(out_ready),
        .gesture(gesture), .previous_gesture(previous_gesture),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    imu_req_t   req_q[$];
    gest_pair_t gest_q[$];
    int         n_errors;
    int         n_results;
    int         n_queued;
    logic [31:0] cur_t;

    // predictor state
    int          ring_acc[RING][3];
    int          ring_gyr[RING][3];
    logic [31:0] ring_t[RING];
    int          fill;
    int          wslot;
    logic [31:0] hit_time;
    logic [3:0]  hit_code;
    longint      grav[3];
    longint      tilt_lim, shake_lim, punch_lim, swipe_lim;
    logic [31:0] debounce;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint unsigned mag(longint x);
        return x < 0 ? longint'(-x) : longint'(x);
    endfunction

    // x^2 > k^2 * s2, full width
    function automatic bit sq_over(longint unsigned x, longint unsigned k,
                                   longint unsigned s2);
        logic [127:0] lhs, rhs;
        lhs = 128'(x) * 128'(x);
        rhs = 128'(k * k) * 128'(s2);
        return lhs > rhs;
    endfunction

    function automatic int slot_back(int k);
        return (wslot + RING - (k % RING)) % RING;
    endfunction

    function automatic gest_t classify_window();
        int n, j, i, d, a, g, p, q;
        longint s[3];
        int amax[3], gmax[3];
        longint unsigned s2, half;
        longint dot, cx, cy, cum, vmax, vmin;
        logic [31:0] dt;
        bit tilt, hit;
        logic [127:0] lhs, rhs;
        n = fill < NEWEST ? fill : NEWEST;
        s = '{0, 0, 0};
        amax = '{0, 0, 0};
        gmax = '{0, 0, 0};
        if (n == 0)
            return G_NONE;
        for (i = 1; i <= n; i++)
        begin
            p = slot_back(i);
            for (j = 0; j < 3; j++)
            begin
                a = int'(mag(ring_acc[p][j]));
                g = int'(mag(ring_gyr[p][j]));
                s[j] += ring_acc[p][j];
                if (a > amax[j]) amax[j] = a;
                if (g > gmax[j]) gmax[j] = g;
            end
        end
        s2 = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
        half = 2048 * n;
        if (s2 <= half * half)
            return G_NONE;
        for (j = 0; j < 3; j++)
            if (gmax[j] > shake_lim)
                return gest_t'(G_SHAKE_X + j);
        if (amax[2] > punch_lim)
        begin
            hit = 1'b0;
            if (fill >= TAIL)
                for (i = TAIL; i > 1; i--)
                begin
                    d = ring_acc[slot_back(i - 1)][2] - ring_acc[slot_back(i)][2];
                    if (d > STEP_LIMIT || d < -STEP_LIMIT) hit = 1'b1;
                end
            return hit ? G_PUNCH : G_NONE;
        end
        dot = s[0] * grav[0] + s[1] * grav[1] + s[2] * grav[2];
        if (dot < 0)
            tilt = 1'b1;
        else
        begin
            lhs = 128'(dot) * 128'(dot);
            rhs = 128'(COS_SQ) * 128'(s2);
            tilt = lhs < rhs;
        end
        if (tilt)
        begin
            cx = grav[1] * s[2] - grav[2] * s[1];
            cy = grav[2] * s[0] - grav[0] * s[2];
            if (mag(cx) > mag(cy))
            begin
                if (sq_over(mag(cx), tilt_lim, s2))
                    return cx > 0 ? G_TILT_F : G_TILT_B;
            end
            else if (sq_over(mag(cy), tilt_lim, s2))
                return cy > 0 ? G_TILT_R : G_TILT_L;
            return G_NONE;
        end
        if (fill >= TAIL)
        begin
            cum = 0;
            vmax = 0;
            vmin = 0;
            for (i = TAIL; i > 1; i--)
            begin
                p = slot_back(i);
                q = slot_back(i - 1);
                dt = ring_t[q] - ring_t[p];
                cum += longint'(ring_acc[p][0]) * longint'({32'd0, dt});
                if (i == TAIL || cum > vmax) vmax = cum;
                if (i == TAIL || cum < vmin) vmin = cum;
            end
            if (vmax > swipe_lim) return G_SWIPE_R;
            if (vmin < -swipe_lim) return G_SWIPE_L;
        end
        return G_NONE;
    endfunction

    // predictor update and result checking
    always @(posedge clk)
    begin : check_blk
        gest_pair_t want, got;
        gest_t      g;
        int         j;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                got.g = gesture;
                got.prev = previous_gesture;
                if (gest_q.size() == 0)
                begin
                    $display("%0t: unexpected result gesture=%0d previous=%0d",
                             $time, got.g, got.prev);
                    n_errors++;
                end
                else
                begin
                    want = gest_q.pop_front();
                    if (got.g !== want.g)
                    begin
                        $display("%0t: gesture expected %0d actual %0d",
                                 $time, want.g, got.g);
                        n_errors++;
                    end
                    if (got.prev !== want.prev)
                    begin
                        $display("%0t: previous_gesture expected %0d actual %0d",
                                 $time, want.prev, got.prev);
                        n_errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_t'(cfg_index))
                    CFG_GRAV_X:   grav[0] = longint'($signed(cfg_data[15:0]));
                    CFG_GRAV_Y:   grav[1] = longint'($signed(cfg_data[15:0]));
                    CFG_GRAV_Z:   grav[2] = longint'($signed(cfg_data[15:0]));
                    CFG_TILT:     tilt_lim = cfg_data[14:0];
                    CFG_SHAKE:    shake_lim = cfg_data[14:0];
                    CFG_PUNCH:    punch_lim = cfg_data[14:0];
                    CFG_SWIPE:    swipe_lim = cfg_data;
                    CFG_DEBOUNCE: debounce = cfg_data[31:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                case (command)
                    CMD_PUSH:
                    begin
                        ring_acc[wslot] = '{int'($signed(accel_x)), int'($signed(accel_y)),
                                            int'($signed(accel_z))};
                        ring_gyr[wslot] = '{int'($signed(gyro_x)), int'($signed(gyro_y)),
                                            int'($signed(gyro_z))};
                        ring_t[wslot] = time_us;
                        wslot = (wslot + 1) % RING;
                        if (fill < RING) fill++;
                    end
                    CMD_CLEAR:
                    begin
                        fill = 0;
                        wslot = 0;
                    end
                    CMD_DETECT:
                    begin
                        g = G_NONE;
                        if (fill >= RING / 2 && (time_us - hit_time) >= debounce)
                            g = classify_window();
                        want.g = g;
                        want.prev = hit_code;
                        if (g != G_NONE)
                        begin
                            hit_code = g;
                            hit_time = time_us;
                        end
                        gest_q.push_back(want);
                    end
                    default: ;
                endcase
            end
        end
    end

    // request driver: bursts with random gaps
    int burst_left;
    int gap_left;
    imu_req_t cur_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= CMD_PUSH;
            {accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z} <= '0;
            time_us <= '0;
            burst_left <= 4;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (req_q.size() > 0)
            begin
                cur_req = req_q.pop_front();
                in_valid <= 1'b1;
                command <= cur_req.cmd;
                accel_x <= cur_req.ax;
                accel_y <= cur_req.ay;
                accel_z <= cur_req.az;
                gyro_x <= cur_req.gx;
                gyro_y <= cur_req.gy;
                gyro_z <= cur_req.gz;
                time_us <= cur_req.t;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: own stall pattern plus one long hold-off
    int rx_cnt;
    int rx_mode;
    int hold_left;
    bit hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cnt <= 0;
            rx_mode <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            rx_cnt <= rx_cnt + 1;
            if (rx_cnt % 300 == 0)
                rx_mode <= $urandom_range(0, 2);
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (n_results >= 40 && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= 4000;
                out_ready <= 1'b0;
            end
            else
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= (rx_cnt % 7) > 2;
                    default: out_ready <= $urandom_range(0, 1);
                endcase
        end
    end

    task automatic add_req(logic [1:0] cmd, int ax, int ay, int az,
                           int gx, int gy, int gz, logic [31:0] t);
        imu_req_t r;
        r.cmd = cmd;
        r.ax = ax[15:0];
        r.ay = ay[15:0];
        r.az = az[15:0];
        r.gx = gx[15:0];
        r.gy = gy[15:0];
        r.gz = gz[15:0];
        r.t = t;
        req_q.push_back(r);
        n_queued++;
    endtask

    function automatic int jitter(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic int signed_in(int lo, int hi);
        int v;
        v = $urandom_range(lo, hi);
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    // one sample shaped after a motion class
    task automatic push_shaped(int kind, int k);
        int ax, ay, az, gx, gy, gz, dt, axis;
        ax = jitter(300);
        ay = jitter(300);
        az = 4096 + jitter(300);
        gx = jitter(200);
        gy = jitter(200);
        gz = jitter(200);
        dt = $urandom_range(500, 1500);
        case (kind)
            1:
            begin
                ax = signed_in(0, 5000);
                ay = signed_in(0, 5000);
                az = $urandom_range(0, 4096);
            end
            2:
            begin
                axis = $urandom_range(0, 2);
                if (axis == 0) gx = signed_in(1500, 32767);
                else if (axis == 1) gy = signed_in(1500, 32767);
                else gz = signed_in(1500, 32767);
            end
            3: az = (k % 2) ? signed_in(4000, 32767) : $urandom_range(0, 4000);
            4:
            begin
                ax = signed_in(8000, 32767);
                dt = $urandom_range(5000, 65535);
            end
            5:
            begin
                ax = $urandom_range(0, 65535);
                ay = $urandom_range(0, 65535);
                az = $urandom_range(0, 65535);
                gx = $urandom_range(0, 65535);
                gy = $urandom_range(0, 65535);
                gz = $urandom_range(0, 65535);
                dt = $urandom();
            end
            default: ;
        endcase
        cur_t = cur_t + dt;
        add_req(CMD_PUSH, ax, ay, az, gx, gy, gz, cur_t);
    endtask

    task automatic detect_now();
        cur_t = cur_t + (($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 400000));
        add_req(CMD_DETECT, $urandom_range(0, 65535), 0, 0, 0, 0, $urandom_range(0, 65535),
                cur_t);
    endtask

    // usually clear, fill with one motion class plus random samples, then a few detects
    task automatic gesture_run();
        int kind, n, i;
        kind = $urandom_range(0, 5);
        if ($urandom_range(0, 5) != 0)
            add_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0, $urandom());
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(5, 70) : $urandom_range(32, 40);
        for (i = 0; i < n; i++)
            push_shaped(($urandom_range(0, 9) == 0) ? 5 : kind, i);
        for (i = $urandom_range(1, 3); i > 0; i--)
        begin
            detect_now();
            if ($urandom_range(0, 2) == 0)
                push_shaped(kind, i);
        end
        if ($urandom_range(0, 9) == 0)
            add_req(2'd3, $urandom(), 0, 0, 0, 0, 0, $urandom());
    endtask

    task automatic write_reg(cfg_t idx, logic [39:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (req_q.size() > 0 || in_valid || gest_q.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_regs(int setting);
        int j;
        if (setting == 1)
        begin
            write_reg(CFG_GRAV_X, 40'hff_ffff_c000);
            write_reg(CFG_GRAV_Y, 40'd0);
            write_reg(CFG_GRAV_Z, 40'd0);
            write_reg(CFG_TILT, 40'd0);
            write_reg(CFG_SHAKE, 40'd0);
            write_reg(CFG_PUNCH, 40'd0);
            write_reg(CFG_SWIPE, 40'd0);
            write_reg(CFG_DEBOUNCE, 40'd0);
        end
        else if (setting == 2)
        begin
            write_reg(CFG_GRAV_X, 40'd0);
            write_reg(CFG_GRAV_Y, 40'd16384);
            write_reg(CFG_GRAV_Z, 40'hff_ffff_c000);
            write_reg(CFG_TILT, 40'd32767);
            write_reg(CFG_SHAKE, 40'd32767);
            write_reg(CFG_PUNCH, 40'd32767);
            write_reg(CFG_SWIPE, 40'hff_ffff_ffff);
            write_reg(CFG_DEBOUNCE, 40'hffff_ffff);
        end
        else
        begin
            for (j = 0; j < 3; j++)
                write_reg(cfg_t'(CFG_GRAV_X + j),
                          ($urandom_range(0, 2) == 0) ? ((j == 2) ? 40'd16384 : 40'd0)
                                                      : 40'(signed_in(0, 16384)));
            write_reg(CFG_TILT, $urandom_range(0, 16384));
            write_reg(CFG_SHAKE, $urandom_range(800, 6000));
            write_reg(CFG_PUNCH, $urandom_range(3000, 16000));
            write_reg(CFG_SWIPE, 40'($urandom_range(100000, 2000000)) * 40'd4000);
            write_reg(CFG_DEBOUNCE, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400000));
        end
    endtask

    initial begin : stim_blk
        int phase, i;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        n_errors = 0;
        n_results = 0;
        n_queued = 0;
        cur_t = 32'hffff_f000;
        fill = 0;
        wslot = 0;
        hit_time = '0;
        hit_code = G_NONE;
        grav = '{0, 0, 16384};
        tilt_lim = 13107;
        shake_lim = 2400;
        punch_lim = 6144;
        swipe_lim = 64'd4915200000;
        debounce = 32'd300000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty detect, extremes, ignored command, clear, wrap of time
        add_req(CMD_DETECT, 0, 0, 0, 0, 0, 0, 32'hffff_ffff);
        add_req(2'd3, -1, -1, -1, -1, -1, -1, 32'hffff_ffff);
        add_req(CMD_PUSH, -32768, -32768, -32768, -32768, -32768, -32768, 32'h0);
        add_req(CMD_PUSH, 32767, 32767, 32767, 32767, 32767, 32767, 32'hffff_ffff);
        add_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        for (i = 0; i < 12; i++)
            push_shaped((i < 6) ? 0 : 3, i);
        add_req(CMD_DETECT, 0, 0, 0, 0, 0, 0, cur_t);
        add_req(CMD_PUSH, 0, 0, 0, 0, 0, 0, cur_t);
        add_req(CMD_DETECT, -1, -1, -1, -1, -1, -1, 32'h0);
        drain();

        for (phase = 0; n_queued < 1250; phase++)
        begin
            set_regs(phase % 5 == 0 ? 3 : phase % 5);
            for (i = 0; i < 4 && n_queued < 1250; i++)
                gesture_run();
            drain();
        end

        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
